[rtl/twtp_pkg.sv]
`timescale 1ns / 1ps

package twtp_pkg;

   // Wheel and pool sizes.
   localparam int Slots  = 60;
   localparam int Timers = 16;
   localparam int MaxOut = 16;

   // Field widths.
   localparam int CmdW     = 2;
   localparam int KindW    = 2;
   localparam int TimeoutW = 16;
   localparam int HandleW  = 4;
   localparam int ValueW   = 32;
   localparam int RoundsW  = 11;

   // Derived widths.
   localparam int IdxW  = (Timers > 1) ? $clog2(Timers) : 1;
   localparam int SlotW = $clog2(Slots);
   localparam int CntW  = $clog2(MaxOut + 1);

   localparam int ReqDataW = ((TimeoutW + HandleW + ValueW + 7) / 8) * 8;
   localparam int RspDataW = ((1 + HandleW + ValueW + 7) / 8) * 8;
   localparam int RspPadW  = RspDataW - 1 - HandleW - ValueW;

   // Reciprocal for dividing the timeout by the slot count. With a shift of
   // timeout width plus slot width the truncated product is the exact quotient.
   localparam int RecipShift = TimeoutW + SlotW;
   localparam int RecipW     = RecipShift + 1;
   localparam int ProdW      = TimeoutW + RecipW;
   localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << RecipShift) / Slots + 1);

   localparam logic [RoundsW-1:0] RoundsMax = '1;

   // Command codes.
   localparam logic [CmdW-1:0] CmdAdd  = 2'd0;
   localparam logic [CmdW-1:0] CmdDel  = 2'd1;
   localparam logic [CmdW-1:0] CmdTick = 2'd2;

   // Result kinds.
   localparam logic [KindW-1:0] KindAdd  = 2'd0;
   localparam logic [KindW-1:0] KindDel  = 2'd1;
   localparam logic [KindW-1:0] KindExp  = 2'd2;
   localparam logic [KindW-1:0] KindNone = 2'd3;

   typedef struct packed {
      logic cap_req;
      logic do_div;
      logic do_rem;
      logic alloc;
      logic add_full;
      logic del;
      logic tick_adv;
      logic dec_rounds;
      logic expire;
      logic tick_end;
      logic idx_inc;
   } ctl_cmd_type;

   typedef struct packed {
      logic free_hit;
      logic idx_last;
      logic due;
      logic rounds_zero;
      logic room;
      logic pend_full;
      logic rsp_free;
   } dp_status_type;

endpackage

[rtl/twtp_ctrl.sv]
`timescale 1ns / 1ps

module twtp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [twtp_pkg::CmdW-1:0]     req_tuser,
   input  twtp_pkg::dp_status_type       status,
   output twtp_pkg::ctl_cmd_type         cmd
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StDiv  = 3'd1;
   localparam logic [2:0] StRem  = 3'd2;
   localparam logic [2:0] StFind = 3'd3;
   localparam logic [2:0] StDel  = 3'd4;
   localparam logic [2:0] StScan = 3'd5;
   localparam logic [2:0] StEnd  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == StIdle);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.cap_req = 1'b1;
               unique case (req_tuser)
                  twtp_pkg::CmdAdd: state_in = StDiv;
                  twtp_pkg::CmdDel: state_in = StDel;
                  twtp_pkg::CmdTick: begin
                     cmd.tick_adv = 1'b1;
                     state_in     = StScan;
                  end
                  default: state_in = StIdle;
               endcase
            end
         end
         StDiv: begin
            cmd.do_div = 1'b1;
            state_in   = StRem;
         end
         StRem: begin
            cmd.do_rem = 1'b1;
            state_in   = StFind;
         end
         StFind: begin
            if (status.free_hit) begin
               if (status.rsp_free) begin
                  cmd.alloc = 1'b1;
                  state_in  = StIdle;
               end
            end else if (status.idx_last) begin
               if (status.rsp_free) begin
                  cmd.add_full = 1'b1;
                  state_in     = StIdle;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         StDel: begin
            if (status.rsp_free) begin
               cmd.del  = 1'b1;
               state_in = StIdle;
            end
         end
         StScan: begin
            // An expiry while one is already held must first push the held
            // one out, so it waits for room in the output register.
            if (status.due && status.rounds_zero && status.room &&
                status.pend_full && !status.rsp_free) begin
               state_in = StScan;
            end else begin
               if (status.due && !status.rounds_zero) begin
                  cmd.dec_rounds = 1'b1;
               end else if (status.due && status.room) begin
                  cmd.expire = 1'b1;
               end
               if (status.idx_last) begin
                  state_in = StEnd;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         StEnd: begin
            if (status.rsp_free) begin
               cmd.tick_end = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/twtp_datapath.sv]
`timescale 1ns / 1ps

module twtp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [twtp_pkg::ReqDataW-1:0]      req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [twtp_pkg::RspDataW-1:0]      rsp_tdata,
   output logic [twtp_pkg::KindW-1:0]         rsp_tuser,
   output logic                               rsp_tlast,
   input  twtp_pkg::ctl_cmd_type              cmd,
   output twtp_pkg::dp_status_type            status
);

   localparam int TW = twtp_pkg::TimeoutW;
   localparam int SW = twtp_pkg::SlotW;
   localparam int IW = twtp_pkg::IdxW;
   localparam int HW = twtp_pkg::HandleW;
   localparam int VW = twtp_pkg::ValueW;
   localparam int RW = twtp_pkg::RoundsW;

   // Captured request.
   logic [TW-1:0] tm1_ff, tm1_in;
   logic [HW-1:0] handle_ff, handle_in;
   logic [VW-1:0] value_ff, value_in;

   // Round count and slot arithmetic.
   logic [TW-1:0] quot_ff, quot_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [twtp_pkg::ProdW-1:0] prod;
   logic [SW:0]   slot_sum;
   logic [SW-1:0] slot_new;
   logic [RW-1:0] rounds_new;

   // Scan index, wheel cursor and timer pool.
   logic [IW-1:0] idx_ff, idx_in;
   logic [SW-1:0] cursor_ff, cursor_in;
   logic [twtp_pkg::Timers-1:0] valid_ff, valid_in;
   logic [SW-1:0] slot_ff   [twtp_pkg::Timers];
   logic [RW-1:0] rounds_ff [twtp_pkg::Timers];
   logic [VW-1:0] store_ff  [twtp_pkg::Timers];

   // Held expiry, so that the final one of a tick can be marked last.
   logic                       pend_valid_ff, pend_valid_in;
   logic [IW-1:0]              pend_idx_ff, pend_idx_in;
   logic [VW-1:0]              pend_value_ff, pend_value_in;
   logic [twtp_pkg::CntW-1:0]  cnt_ff, cnt_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [twtp_pkg::KindW-1:0]    rsp_kind_ff, rsp_kind_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic [HW-1:0]                 rsp_handle_ff, rsp_handle_in;
   logic [VW-1:0]                 rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [IW-1:0] del_idx;
   logic          del_hit;
   logic          rsp_free;
   logic          push_pend;

   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign push_pend = cmd.expire && pend_valid_ff;
   assign del_idx   = IW'(handle_ff);
   assign del_hit   = (32'(handle_ff) < twtp_pkg::Timers) && valid_ff[del_idx];

   assign prod = twtp_pkg::ProdW'(tm1_ff) * twtp_pkg::ProdW'(twtp_pkg::Recip);

   // The remainder is below the slot count and the cursor plus one is at most
   // the slot count, so one conditional subtract finishes the modulo.
   assign slot_sum = (SW+1)'(cursor_ff) + (SW+1)'(1) + (SW+1)'(rem_ff);
   assign slot_new = (slot_sum >= (SW+1)'(twtp_pkg::Slots)) ?
                     SW'(slot_sum - (SW+1)'(twtp_pkg::Slots)) : SW'(slot_sum);
   assign rounds_new = (quot_ff > TW'(twtp_pkg::RoundsMax)) ?
                       twtp_pkg::RoundsMax : RW'(quot_ff);

   always_comb begin
      status.free_hit    = !valid_ff[idx_ff];
      status.idx_last    = (idx_ff == IW'(twtp_pkg::Timers - 1));
      status.due         = valid_ff[idx_ff] && (slot_ff[idx_ff] == cursor_ff);
      status.rounds_zero = (rounds_ff[idx_ff] == '0);
      status.room        = (cnt_ff < twtp_pkg::CntW'(twtp_pkg::MaxOut));
      status.pend_full   = pend_valid_ff;
      status.rsp_free    = rsp_free;
   end

   always_comb begin
      tm1_in        = tm1_ff;
      handle_in     = handle_ff;
      value_in      = value_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      cursor_in     = cursor_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_value_in = pend_value_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.cap_req) begin
         // A zero timeout counts as one tick.
         tm1_in    = (req_tdata[TW-1:0] == '0) ? '0 : req_tdata[TW-1:0] - TW'(1);
         handle_in = req_tdata[TW+HW-1:TW];
         value_in  = req_tdata[TW+HW+VW-1:TW+HW];
         idx_in    = '0;
      end
      if (cmd.do_div) begin
         quot_in = TW'(prod >> twtp_pkg::RecipShift);
      end
      if (cmd.do_rem) begin
         rem_in = SW'(tm1_ff - TW'(quot_ff * TW'(twtp_pkg::Slots)));
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.tick_adv) begin
         cursor_in     = (cursor_ff == SW'(twtp_pkg::Slots - 1)) ?
                         '0 : cursor_ff + SW'(1);
         pend_valid_in = 1'b0;
         cnt_in        = '0;
      end
      if (cmd.alloc) begin
         valid_in[idx_ff] = 1'b1;
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = twtp_pkg::KindAdd;
         rsp_status_in    = 1'b0;
         rsp_handle_in    = HW'(idx_ff);
         rsp_value_in     = '0;
         rsp_last_in      = 1'b1;
      end
      if (cmd.add_full) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = twtp_pkg::KindAdd;
         rsp_status_in = 1'b1;
         rsp_handle_in = '0;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b1;
      end
      if (cmd.del) begin
         if (del_hit) begin
            valid_in[del_idx] = 1'b0;
         end
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = twtp_pkg::KindDel;
         rsp_status_in = !del_hit;
         rsp_handle_in = '0;
         rsp_value_in  = '0;
         rsp_last_in   = 1'b1;
      end
      if (cmd.expire) begin
         valid_in[idx_ff] = 1'b0;
         pend_valid_in    = 1'b1;
         pend_idx_in      = idx_ff;
         pend_value_in    = store_ff[idx_ff];
         cnt_in           = cnt_ff + twtp_pkg::CntW'(1);
      end
      if (push_pend) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = twtp_pkg::KindExp;
         rsp_status_in = 1'b0;
         rsp_handle_in = HW'(pend_idx_ff);
         rsp_value_in  = pend_value_ff;
         rsp_last_in   = 1'b0;
      end
      if (cmd.tick_end) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b0;
         rsp_last_in   = 1'b1;
         if (pend_valid_ff) begin
            rsp_kind_in   = twtp_pkg::KindExp;
            rsp_handle_in = HW'(pend_idx_ff);
            rsp_value_in  = pend_value_ff;
         end else begin
            rsp_kind_in   = twtp_pkg::KindNone;
            rsp_handle_in = '0;
            rsp_value_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         cursor_ff     <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         cursor_ff     <= cursor_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tm1_ff        <= tm1_in;
      handle_ff     <= handle_in;
      value_ff      <= value_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      pend_idx_ff   <= pend_idx_in;
      pend_value_ff <= pend_value_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Timer entries.
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         slot_ff[idx_ff]   <= slot_new;
         rounds_ff[idx_ff] <= rounds_new;
         store_ff[idx_ff]  <= value_ff;
      end else if (cmd.dec_rounds) begin
         rounds_ff[idx_ff] <= rounds_ff[idx_ff] - RW'(1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{twtp_pkg::RspPadW{1'b0}}, rsp_value_ff, rsp_handle_ff, rsp_status_ff};

endmodule

[rtl/timing_wheel_timer_pool_core.sv]
`timescale 1ns / 1ps
// One item is worked on at a time; a new item is taken once the previous one's last result is
// in the output register. Add: capture, divide and remainder for round and slot arithmetic,
// then a free-entry search. Delete: capture, then lookup and reply. Tick: capture with cursor
// advance, a scan of all entries, then the final result; a waiting output register stalls them.
// Reset clears the cursor, all entry valid bits and the output register; no clearing pass.

module timing_wheel_timer_pool_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // timeout [15:0], handle [19:16], user_value [51:20], zero pad [55:52]
   input  logic [twtp_pkg::ReqDataW-1:0]      req_tdata,
   // cmd [1:0]
   input  logic [twtp_pkg::CmdW-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [0], result_handle [4:1], expired_value [36:5], zero pad [39:37]
   output logic [twtp_pkg::RspDataW-1:0]      rsp_tdata,
   // kind [1:0]
   output logic [twtp_pkg::KindW-1:0]         rsp_tuser,
   output logic                               rsp_tlast
);

   twtp_pkg::ctl_cmd_type   ctl_cmd;
   twtp_pkg::dp_status_type dp_status;

   twtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (dp_status),
      .cmd        (ctl_cmd)
   );

   twtp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (ctl_cmd),
      .status     (dp_status)
   );

`ifndef SYNTH
   // Add, delete and empty-tick replies are single beats.
   a_single_beat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == twtp_pkg::KindAdd || rsp_tuser == twtp_pkg::KindDel ||
                     rsp_tuser == twtp_pkg::KindNone) |-> rsp_tlast)
      else $error("single-beat reply without last");

   // A failed add carries no handle.
   a_full_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == twtp_pkg::KindAdd && rsp_tdata[0]
      |-> rsp_tdata[twtp_pkg::HandleW:1] == '0)
      else $error("full add reply carries a handle");

   // No new request is taken while a tick scan retires timers.
   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && (ctl_cmd.expire || ctl_cmd.dec_rounds)))
      else $error("request accepted during tick scan");

   // A held expiry is only pushed out when the output register has room.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.expire && dp_status.pend_full |-> dp_status.rsp_free)
      else $error("held expiry pushed into a full output register");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [twtp_pkg::KindW-1:0]   kind;
      logic                         status;
      logic [twtp_pkg::HandleW-1:0] hnd;
      logic [twtp_pkg::ValueW-1:0]  value;
      logic                         last;
   } wheel_result_type;

   localparam int unsigned CycleLimit = 1000000;
   localparam logic [twtp_pkg::CmdW-1:0] CmdIgnored = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [twtp_pkg::ReqDataW-1:0] req_tdata = '0;
   logic [twtp_pkg::CmdW-1:0]     req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [twtp_pkg::RspDataW-1:0] rsp_tdata;
   logic [twtp_pkg::KindW-1:0]    rsp_tuser;
   logic                          rsp_tlast;

   // Own copy of the wheel, updated as each beat is accepted.
   int unsigned                   wheel_cursor = 0;
   bit                            ent_live [twtp_pkg::Timers];
   logic [twtp_pkg::SlotW-1:0]    ent_slot [twtp_pkg::Timers];
   logic [twtp_pkg::RoundsW-1:0]  ent_rounds [twtp_pkg::Timers];
   logic [twtp_pkg::ValueW-1:0]   ent_value [twtp_pkg::Timers];

   wheel_result_type    due_results [$];
   int unsigned         fail_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         rsp_hold = 0;
   bit                  calm = 1'b0;

   timing_wheel_timer_pool_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timing_wheel_timer_pool_core test failed");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one and now and then a long one.
   function automatic int unsigned gap_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int unsigned random_timeout();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 20);
      if (r < 85) return $urandom_range(21, 180);
      return $urandom_range(0, 65535);
   endfunction

   task automatic push_result(input logic [twtp_pkg::KindW-1:0] kind, input logic status,
                              input logic [twtp_pkg::HandleW-1:0] hnd,
                              input logic [twtp_pkg::ValueW-1:0] value, input logic last);
      wheel_result_type r;
      r.kind   = kind;
      r.status = status;
      r.hnd    = hnd;
      r.value  = value;
      r.last   = last;
      due_results.push_back(r);
   endtask

   task automatic wheel_predict(input logic [twtp_pkg::CmdW-1:0] cmd,
                                input logic [twtp_pkg::TimeoutW-1:0] tmo,
                                input logic [twtp_pkg::HandleW-1:0] hnd,
                                input logic [twtp_pkg::ValueW-1:0] value);
      int               free_idx;
      int               fired;
      int unsigned      ticks;
      int unsigned      rounds;
      wheel_result_type tail;
      unique case (cmd)
         twtp_pkg::CmdAdd: begin
            free_idx = -1;
            for (int i = 0; i < twtp_pkg::Timers; i++) begin
               if (!ent_live[i] && free_idx < 0) free_idx = i;
            end
            if (free_idx < 0) begin
               push_result(twtp_pkg::KindAdd, 1'b1, '0, '0, 1'b1);
            end else begin
               ticks  = (tmo == 0) ? 1 : tmo;
               rounds = (ticks - 1) / twtp_pkg::Slots;
               if (rounds > twtp_pkg::RoundsMax) rounds = twtp_pkg::RoundsMax;
               ent_live[free_idx]   = 1'b1;
               ent_slot[free_idx]   =
                  twtp_pkg::SlotW'((wheel_cursor + ticks) % twtp_pkg::Slots);
               ent_rounds[free_idx] = twtp_pkg::RoundsW'(rounds);
               ent_value[free_idx]  = value;
               push_result(twtp_pkg::KindAdd, 1'b0, twtp_pkg::HandleW'(free_idx), '0, 1'b1);
            end
         end
         twtp_pkg::CmdDel: begin
            if (hnd < twtp_pkg::Timers && ent_live[hnd]) begin
               ent_live[hnd] = 1'b0;
               push_result(twtp_pkg::KindDel, 1'b0, '0, '0, 1'b1);
            end else begin
               push_result(twtp_pkg::KindDel, 1'b1, '0, '0, 1'b1);
            end
         end
         twtp_pkg::CmdTick: begin
            fired = 0;
            wheel_cursor = (wheel_cursor + 1) % twtp_pkg::Slots;
            for (int i = 0; i < twtp_pkg::Timers; i++) begin
               if (ent_live[i] && ent_slot[i] == wheel_cursor) begin
                  if (ent_rounds[i] != 0) begin
                     ent_rounds[i] = ent_rounds[i] - 1'b1;
                  end else if (fired < twtp_pkg::MaxOut) begin
                     push_result(twtp_pkg::KindExp, 1'b0, twtp_pkg::HandleW'(i),
                                 ent_value[i], 1'b0);
                     ent_live[i] = 1'b0;
                     fired++;
                  end
               end
            end
            if (fired == 0) begin
               push_result(twtp_pkg::KindNone, 1'b0, '0, '0, 1'b1);
            end else begin
               tail = due_results.pop_back();
               tail.last = 1'b1;
               due_results.push_back(tail);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Sends one beat and returns at the edge that accepts it, with tvalid still high.
   task automatic send_item(input logic [twtp_pkg::CmdW-1:0] cmd, input int unsigned tmo,
                            input int unsigned hnd,
                            input logic [twtp_pkg::ValueW-1:0] value);
      int unsigned gap;
      gap = gap_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= twtp_pkg::ReqDataW'({value, twtp_pkg::HandleW'(hnd),
                                         twtp_pkg::TimeoutW'(tmo)});
      do @(posedge clock); while (!req_tready);
      wheel_predict(cmd, twtp_pkg::TimeoutW'(tmo), twtp_pkg::HandleW'(hnd), value);
   endtask

   always @(posedge clock) begin
      wheel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("result beat with no result outstanding");
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[twtp_pkg::HandleW:1] !== want.hnd) begin
                  $error("result_handle: expected %0d, got %0d", want.hnd,
                         rsp_tdata[twtp_pkg::HandleW:1]);
                  fail_count++;
               end
               if (rsp_tdata[twtp_pkg::HandleW+twtp_pkg::ValueW:twtp_pkg::HandleW+1]
                   !== want.value) begin
                  $error("expired_value: expected %0d, got %0d", $signed(want.value),
                         $signed(rsp_tdata[twtp_pkg::HandleW+twtp_pkg::ValueW:
                                           twtp_pkg::HandleW+1]));
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
            rsp_hold = gap_len();
         end else if (rsp_hold == 0 && $urandom_range(0, 15) == 0) begin
            rsp_hold = gap_len();
         end
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_single_timers();
      send_item(twtp_pkg::CmdAdd, 0, 0, 32'h7fff_ffff);
      send_item(twtp_pkg::CmdAdd, 1, 15, 32'h8000_0000);
      // Both timers share the next slot, so one tick fires two beats.
      send_item(twtp_pkg::CmdTick, 0, 0, '0);
      send_item(CmdIgnored, 65535, 15, 32'hffff_ffff);
      send_item(twtp_pkg::CmdDel, 0, 15, '0);
      send_item(twtp_pkg::CmdAdd, 65535, 0, 32'hffff_ffff);
      send_item(twtp_pkg::CmdDel, 0, 0, '0);
      send_item(twtp_pkg::CmdTick, 0, 0, '0);
   endtask

   task automatic test_pool_full();
      for (int i = 0; i < twtp_pkg::Timers; i++) send_item(twtp_pkg::CmdAdd, 2, 0, $urandom);
      send_item(twtp_pkg::CmdAdd, 5, 0, $urandom);
      send_item(twtp_pkg::CmdTick, 0, 0, '0);
      send_item(twtp_pkg::CmdTick, 0, 0, '0);
      send_item(twtp_pkg::CmdDel, 0, 15, '0);
   endtask

   task automatic test_random_mix();
      int          sent;
      int unsigned pick;
      int unsigned burst;
      int unsigned tmo;
      int          live [$];
      sent = 0;
      while (sent < 440) begin
         calm = ((sent / 40) % 4 == 3);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // A cluster of timers landing in one slot.
            tmo   = $urandom_range(0, 8);
            burst = $urandom_range(3, 8);
            repeat (burst) send_item(twtp_pkg::CmdAdd, tmo, $urandom_range(0, 15), $urandom);
            sent += burst;
         end else if (pick < 42) begin
            send_item(twtp_pkg::CmdAdd, random_timeout(), $urandom_range(0, 15), $urandom);
            sent++;
         end else if (pick < 60) begin
            live.delete();
            for (int i = 0; i < twtp_pkg::Timers; i++) if (ent_live[i]) live.push_back(i);
            if (live.size() != 0 && $urandom_range(0, 3) != 0)
               send_item(twtp_pkg::CmdDel, $urandom,
                         live[$urandom_range(0, live.size() - 1)], $urandom);
            else
               send_item(twtp_pkg::CmdDel, $urandom, $urandom_range(0, 15), $urandom);
            sent++;
         end else if (pick < 95) begin
            send_item(twtp_pkg::CmdTick, $urandom, $urandom_range(0, 15), $urandom);
            sent++;
         end else begin
            send_item(CmdIgnored, $urandom_range(0, 65535), $urandom_range(0, 15), $urandom);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_timers();
      test_pool_full();
      test_random_mix();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("timing_wheel_timer_pool_core test passed");
      end else begin
         $display("timing_wheel_timer_pool_core test failed");
      end
      $finish;
   end

endmodule
